// ===== sv/ucc_pkg.sv =====
// ----------------------------------------------------------------------------
// ucc_pkg
// Types and codes shared by the UPS source and charge controller modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ucc_pkg;

  localparam int unsigned VoltsW = 9;
  localparam int unsigned ClassW = 3;
  localparam int unsigned ActW   = 2;
  localparam int unsigned SwW    = 2;

  localparam logic [VoltsW-1:0] AcDropThresholdRst = 9'd190;

  localparam logic CMD_AC      = 1'b0;
  localparam logic CMD_BATTERY = 1'b1;

  localparam logic [ActW-1:0] ACT_KEEP = 2'd0;
  localparam logic [ActW-1:0] ACT_OFF  = 2'd1;
  localparam logic [ActW-1:0] ACT_ON   = 2'd2;

  localparam logic [SwW-1:0] SW_NONE        = 2'd0;
  localparam logic [SwW-1:0] SW_TO_MAINS    = 2'd1;
  localparam logic [SwW-1:0] SW_TO_INVERTER = 2'd2;

  localparam logic [ClassW-1:0] CLS_NONE       = 3'd0;
  localparam logic [ClassW-1:0] CLS_DISCHARGED = 3'd1;
  localparam logic [ClassW-1:0] CLS_LOW        = 3'd2;
  localparam logic [ClassW-1:0] CLS_MID        = 3'd3;
  localparam logic [ClassW-1:0] CLS_HIGH       = 3'd4;
  localparam logic [ClassW-1:0] CLS_FULL       = 3'd5;

  typedef enum logic [2:0] {
    PH_UNKNOWN  = 3'd0,
    PH_REQUIRED = 3'd1,
    PH_CHARGING = 3'd2,
    PH_END      = 3'd3,
    PH_NOT      = 3'd4
  } charge_phase_t;

  typedef struct packed {
    logic              cmd;
    logic [VoltsW-1:0] ac_volts;
    logic [ClassW-1:0] battery_class;
    logic              ups_relay_is_on;
  } item_t;

  typedef struct packed {
    logic [ActW-1:0] ups_relay_action;
    logic [ActW-1:0] charge_relay_action;
    logic [SwW-1:0]  source_switch;
    logic            long_settle;
    logic            restart_sampling;
    logic [2:0]      charge_phase;
    logic            on_mains;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/ucc_in_stage.sv =====
// ----------------------------------------------------------------------------
// ucc_in_stage
// Input register: captures one item per cycle and holds it while the result
// register is blocked.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ucc_in_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire ucc_pkg::item_t in_item,
  input  wire logic           out_free,
  output logic                s1_fire,
  output ucc_pkg::item_t      s1_item
);

  logic           s1_valid_r;
  logic           s1_valid_nxt;
  ucc_pkg::item_t s1_item_r;
  logic           load;

  assign s1_fire  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign load     = in_valid && !in_stall;
  assign s1_item  = s1_item_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (load) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ucc_core.sv =====
// ----------------------------------------------------------------------------
// ucc_core
// Controller state and decision logic: source switching and ups relay actions
// on ac items, charge state machine and relay actions on battery ticks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ucc_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           step,
  input  wire ucc_pkg::item_t                 item,
  input  wire logic [ucc_pkg::VoltsW-1:0]     ac_drop_threshold,
  output ucc_pkg::result_t                    result
);

  logic                          mains_selected_r, mains_selected_nxt;
  logic                          ac_present_r, ac_present_nxt;
  logic                          ac_last_acted_r, ac_last_acted_nxt;
  logic                          first_pass_r, first_pass_nxt;
  ucc_pkg::charge_phase_t        charge_state_r, charge_state_nxt;
  logic [ucc_pkg::ClassW-1:0]    battery_level_r, battery_level_nxt;

  logic                          is_ac;
  logic                          ac_now;
  logic                          to_mains;
  logic                          to_inverter;
  ucc_pkg::charge_phase_t        phase_step;
  logic                          first_pass_step;
  logic [ucc_pkg::ActW-1:0]      charge_act;
  logic [ucc_pkg::ActW-1:0]      ups_act_batt;

  assign is_ac       = (item.cmd == ucc_pkg::CMD_AC);
  assign ac_now      = item.ac_volts > ac_drop_threshold;
  assign to_mains    = (ac_now != ac_last_acted_r) && ac_now && !mains_selected_r;
  assign to_inverter = (ac_now != ac_last_acted_r) && !ac_now && mains_selected_r;

  // charge state machine: next state
  always_comb begin
    phase_step      = ucc_pkg::PH_REQUIRED;
    first_pass_step = first_pass_r;
    case (charge_state_r)
      ucc_pkg::PH_REQUIRED: begin
        if (!ac_present_r) begin
          phase_step = ucc_pkg::PH_NOT;
        end else if (item.battery_class <= ucc_pkg::CLS_MID) begin
          phase_step = ucc_pkg::PH_CHARGING;
        end else if (first_pass_r) begin
          phase_step      = ucc_pkg::PH_CHARGING;
          first_pass_step = 1'b0;
        end else begin
          phase_step = ucc_pkg::PH_REQUIRED;
        end
      end
      ucc_pkg::PH_CHARGING: begin
        if (!ac_present_r) begin
          phase_step = ucc_pkg::PH_NOT;
        end else if (item.battery_class == ucc_pkg::CLS_FULL) begin
          phase_step = ucc_pkg::PH_END;
        end else begin
          phase_step = ucc_pkg::PH_CHARGING;
        end
      end
      ucc_pkg::PH_END: begin
        phase_step = ac_present_r ? ucc_pkg::PH_NOT : ucc_pkg::PH_REQUIRED;
      end
      ucc_pkg::PH_NOT: begin
        phase_step = (item.battery_class <= ucc_pkg::CLS_HIGH) ?
                     ucc_pkg::PH_REQUIRED : ucc_pkg::PH_NOT;
      end
      default: begin
        phase_step = ucc_pkg::PH_REQUIRED;
      end
    endcase
  end

  // charge state machine: relay output
  always_comb begin
    charge_act = ucc_pkg::ACT_KEEP;
    case (charge_state_r)
      ucc_pkg::PH_CHARGING: begin
        if (ac_present_r) begin
          charge_act = ucc_pkg::ACT_ON;
        end
      end
      ucc_pkg::PH_NOT: begin
        charge_act = ucc_pkg::ACT_OFF;
      end
      default: begin
        charge_act = ucc_pkg::ACT_KEEP;
      end
    endcase
  end

  // ups relay from battery class
  always_comb begin
    ups_act_batt = ucc_pkg::ACT_KEEP;
    case (item.battery_class)
      ucc_pkg::CLS_NONE, ucc_pkg::CLS_DISCHARGED: begin
        ups_act_batt = ucc_pkg::ACT_OFF;
      end
      ucc_pkg::CLS_LOW: begin
        if (ac_last_acted_r && !mains_selected_r) begin
          ups_act_batt = ucc_pkg::ACT_OFF;
        end
      end
      ucc_pkg::CLS_HIGH, ucc_pkg::CLS_FULL: begin
        ups_act_batt = ucc_pkg::ACT_ON;
      end
      default: begin
        ups_act_batt = ucc_pkg::ACT_KEEP;
      end
    endcase
  end

  always_comb begin
    mains_selected_nxt = mains_selected_r;
    ac_present_nxt     = ac_present_r;
    ac_last_acted_nxt  = ac_last_acted_r;
    first_pass_nxt     = first_pass_r;
    charge_state_nxt   = charge_state_r;
    battery_level_nxt  = battery_level_r;

    result.ups_relay_action    = ucc_pkg::ACT_KEEP;
    result.charge_relay_action = ucc_pkg::ACT_KEEP;
    result.source_switch       = ucc_pkg::SW_NONE;
    result.long_settle         = 1'b0;
    result.restart_sampling    = 1'b0;

    if (is_ac) begin
      ac_present_nxt = ac_now;
      if (to_mains) begin
        result.source_switch    = ucc_pkg::SW_TO_MAINS;
        result.restart_sampling = 1'b1;
        mains_selected_nxt      = 1'b1;
        ac_last_acted_nxt       = ac_now;
        if ((battery_level_r < ucc_pkg::CLS_HIGH) && item.ups_relay_is_on) begin
          result.ups_relay_action = ucc_pkg::ACT_OFF;
        end
      end else if (to_inverter) begin
        result.source_switch    = ucc_pkg::SW_TO_INVERTER;
        result.restart_sampling = 1'b1;
        result.long_settle      = !item.ups_relay_is_on;
        mains_selected_nxt      = 1'b0;
        ac_last_acted_nxt       = ac_now;
        if ((battery_level_r > ucc_pkg::CLS_DISCHARGED) && !item.ups_relay_is_on) begin
          result.ups_relay_action = ucc_pkg::ACT_ON;
        end
      end
    end else begin
      battery_level_nxt          = item.battery_class;
      charge_state_nxt           = phase_step;
      first_pass_nxt             = first_pass_step;
      result.charge_relay_action = charge_act;
      result.ups_relay_action    = ups_act_batt;
    end

    result.charge_phase = charge_state_nxt;
    result.on_mains     = mains_selected_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mains_selected_r <= 1'b1;
      ac_present_r     <= 1'b0;
      ac_last_acted_r  <= 1'b1;
      first_pass_r     <= 1'b1;
      charge_state_r   <= ucc_pkg::PH_UNKNOWN;
      battery_level_r  <= ucc_pkg::CLS_NONE;
    end else if (step) begin
      mains_selected_r <= mains_selected_nxt;
      ac_present_r     <= ac_present_nxt;
      ac_last_acted_r  <= ac_last_acted_nxt;
      first_pass_r     <= first_pass_nxt;
      charge_state_r   <= charge_state_nxt;
      battery_level_r  <= battery_level_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ucc_out_stage.sv =====
// ----------------------------------------------------------------------------
// ucc_out_stage
// Result register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ucc_out_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire ucc_pkg::result_t result,
  output logic                  out_free,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output ucc_pkg::result_t      out_result
);

  logic             out_valid_r;
  logic             out_valid_nxt;
  ucc_pkg::result_t out_result_r;

  assign out_free   = !out_valid_r || !out_stall;
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_result_r <= result;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ups_source_and_charge_controller.sv =====
// ----------------------------------------------------------------------------
// ups_source_and_charge_controller
// UPS controller: mains/inverter source switching and battery charge control.
// ----------------------------------------------------------------------------
// path: an accepted item goes through the input register, then the result
//   register, whose out_valid marks the result ready to be taken
// throughput: 1 item per cycle while out_stall is low, set by the
//   single-pass decision logic
// reset: synchronous active-low rst_n clears both stages, resets controller
//   state to its reset values and sets the drop threshold to 190 V
`timescale 1ns / 1ps
`default_nettype none

module ups_source_and_charge_controller (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [ucc_pkg::VoltsW-1:0]    cfg_wr_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_cmd,
  input  wire logic [ucc_pkg::VoltsW-1:0]    in_ac_volts,
  input  wire logic [ucc_pkg::ClassW-1:0]    in_battery_class,
  input  wire logic                          in_ups_relay_is_on,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [ucc_pkg::ActW-1:0]           out_ups_relay_action,
  output logic [ucc_pkg::ActW-1:0]           out_charge_relay_action,
  output logic [ucc_pkg::SwW-1:0]            out_source_switch,
  output logic                               out_long_settle,
  output logic                               out_restart_sampling,
  output logic [2:0]                         out_charge_phase,
  output logic                               out_on_mains
);

  logic [ucc_pkg::VoltsW-1:0] ac_drop_threshold_r;
  ucc_pkg::item_t             in_item;
  ucc_pkg::item_t             s1_item;
  ucc_pkg::result_t           result;
  ucc_pkg::result_t           out_result;
  logic                       out_free;
  logic                       s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ac_drop_threshold_r <= ucc_pkg::AcDropThresholdRst;
    end else if (cfg_wr_en) begin
      ac_drop_threshold_r <= cfg_wr_data;
    end
  end

  assign in_item.cmd             = in_cmd;
  assign in_item.ac_volts        = in_ac_volts;
  assign in_item.battery_class   = in_battery_class;
  assign in_item.ups_relay_is_on = in_ups_relay_is_on;

  ucc_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_free (out_free),
    .s1_fire  (s1_fire),
    .s1_item  (s1_item)
  );

  ucc_core u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .step              (s1_fire),
    .item              (s1_item),
    .ac_drop_threshold (ac_drop_threshold_r),
    .result            (result)
  );

  ucc_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (s1_fire),
    .result     (result),
    .out_free   (out_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  assign out_ups_relay_action    = out_result.ups_relay_action;
  assign out_charge_relay_action = out_result.charge_relay_action;
  assign out_source_switch       = out_result.source_switch;
  assign out_long_settle         = out_result.long_settle;
  assign out_restart_sampling    = out_result.restart_sampling;
  assign out_charge_phase        = out_result.charge_phase;
  assign out_on_mains            = out_result.on_mains;

endmodule

`default_nettype wire
